FILE: hw/rtl/pstb_pkg.sv
// shared widths, codes, register decode and record types of the input table builder
package pstb_pkg;

  localparam int MAX_INPUTS_DEF = 32;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 6;
  localparam int SEM_W  = 8;
  localparam int POS_W  = 5;
  localparam int PGEN_W = 4;
  localparam int GPR_W  = 7;
  localparam int KEY_W  = 64;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index as taken from paddr[2]
  localparam logic REG_PS_IN_CONTROL = 1'b0;

  // transaction kinds
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_WORD  = 1'b1;

  // key mixing
  localparam int              KEY_ROT_LEFT  = 7;
  localparam int              PGEN_ROT      = 7;
  localparam int              GPR_ROT       = 3;
  localparam logic [KEY_W-1:0] POS_KEY_ADD  = 64'h33;

  // control word bit positions
  localparam int FLAT_BIT   = 10;
  localparam int NOPERS_BIT = 12;

  typedef struct packed {
    logic              pos_en;
    logic [POS_W-1:0]  pos_addr;
    logic [PGEN_W-1:0] pgen;
    logic [GPR_W-1:0]  pgen_gpr;
    logic [CNT_W-1:0]  count;
  } ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] next_entry;
    logic [CNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  entry_index;
    logic [SEM_W-1:0]  semantic_id;
    logic              is_position;
    logic              is_flat;
    logic              no_perspective;
    logic [PGEN_W-1:0] param_gen;
    logic [GPR_W-1:0]  param_gen_gpr;
    logic [CNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]  table_key;
    logic              accepted;
    logic              table_done;
  } result_t;

  function automatic ctl_t decode_ctl(input logic [WORD_W-1:0] w);
    ctl_t c;
    c.count    = w[5:0];
    c.pos_en   = w[8];
    c.pos_addr = w[14:10];
    c.pgen     = w[18:15];
    c.pgen_gpr = w[25:19];
    return c;
  endfunction

endpackage

FILE: hw/rtl/pstb_if.sv
// stream interfaces for control word and table entry transactions
interface pstb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [pstb_pkg::WORD_W-1:0] control_word;

  modport source (output valid, action, control_word, input ready);
  modport sink   (input valid, action, control_word, output ready);
endinterface

interface pstb_out_if;
  logic                        valid;
  logic                        ready;
  logic [pstb_pkg::CNT_W-1:0]  entry_index;
  logic [pstb_pkg::SEM_W-1:0]  semantic_id;
  logic                        is_position;
  logic                        is_flat;
  logic                        no_perspective;
  logic [pstb_pkg::PGEN_W-1:0] param_gen;
  logic [pstb_pkg::GPR_W-1:0]  param_gen_gpr;
  logic [pstb_pkg::CNT_W-1:0]  entry_count;
  logic [pstb_pkg::KEY_W-1:0]  table_key;
  logic                        accepted;
  logic                        table_done;

  modport source (output valid, entry_index, semantic_id, is_position, is_flat,
                  no_perspective, param_gen, param_gen_gpr, entry_count, table_key,
                  accepted, table_done, input ready);
  modport sink   (input valid, entry_index, semantic_id, is_position, is_flat,
                  no_perspective, param_gen, param_gen_gpr, entry_count, table_key,
                  accepted, table_done, output ready);
endinterface

FILE: hw/rtl/pstb_apb_regs.sv
// apb register file holding the shader input control register
module pstb_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pstb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pstb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pstb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [pstb_pkg::WORD_W-1:0]      ps_in_control
);

  logic wr_en;
  logic sel_ctl;

  assign pready  = 1'b1;
  assign sel_ctl = (paddr[2] == pstb_pkg::REG_PS_IN_CONTROL);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps_in_control <= '0;
    end else if (wr_en && sel_ctl) begin
      ps_in_control <= pwdata[pstb_pkg::WORD_W-1:0];
    end
  end

  assign prdata = sel_ctl ? ps_in_control : '0;

endmodule

FILE: hw/rtl/pstb_step.sv
// per-transaction table step: key seeding, key mixing and entry decode
module pstb_step #(
  parameter int MAX_INPUTS = pstb_pkg::MAX_INPUTS_DEF
) (
  input  logic                         action,
  input  logic [pstb_pkg::WORD_W-1:0]  control_word,
  input  logic [pstb_pkg::WORD_W-1:0]  ps_in_control,
  input  pstb_pkg::state_t             state,
  output pstb_pkg::state_t             state_next,
  output pstb_pkg::result_t            result
);

  localparam int KW = pstb_pkg::KEY_W;
  localparam int CW = pstb_pkg::CNT_W;
  localparam int RL = pstb_pkg::KEY_ROT_LEFT;

  pstb_pkg::ctl_t ctl;
  logic [CW-1:0]  cnt_clamped;
  logic [KW-1:0]  seed;
  logic [KW-1:0]  pgen_term;
  logic [KW-1:0]  gpr_term;
  logic [KW-1:0]  mix_sum;
  logic [KW-1:0]  mix_rot;
  logic [CW-1:0]  entry_inc;
  logic           pos_hit;

  always_comb begin
    ctl = pstb_pkg::decode_ctl(ps_in_control);

    cnt_clamped = (ctl.count > CW'(MAX_INPUTS)) ? CW'(MAX_INPUTS) : ctl.count;

    // rotate-right of narrow fields is a fixed bit placement
    pgen_term = KW'(ctl.pgen) << (KW - pstb_pkg::PGEN_ROT);
    gpr_term  = {ctl.pgen_gpr[pstb_pkg::GPR_ROT-1:0],
                 {(KW-pstb_pkg::GPR_W){1'b0}},
                 ctl.pgen_gpr[pstb_pkg::GPR_W-1:pstb_pkg::GPR_ROT]};

    seed = '0;
    if (ctl.pos_en) begin
      seed = KW'(ctl.pos_addr) + KW'(1);
    end
    if (ctl.pgen != '0) begin
      seed = seed + pgen_term + gpr_term;
    end

    mix_sum   = state.key + KW'(control_word);
    mix_rot   = {mix_sum[KW-RL-1:0], mix_sum[KW-1:KW-RL]};
    entry_inc = state.next_entry + CW'(1);
    pos_hit   = ctl.pos_en && (state.next_entry == CW'(ctl.pos_addr));

    state_next = state;

    result.entry_index    = '0;
    result.semantic_id    = '0;
    result.is_position    = 1'b0;
    result.is_flat        = 1'b0;
    result.no_perspective = 1'b0;
    result.param_gen      = ctl.pgen;
    result.param_gen_gpr  = (ctl.pgen != '0) ? ctl.pgen_gpr : '0;
    result.accepted       = 1'b1;
    result.table_done     = 1'b1;

    if (action == pstb_pkg::ACT_BEGIN) begin
      state_next.key        = seed;
      state_next.next_entry = '0;
      state_next.count      = cnt_clamped;
      result.table_done     = (cnt_clamped == '0);
    end else if (state.next_entry < state.count) begin
      result.entry_index    = state.next_entry;
      if (pos_hit) begin
        result.is_position  = 1'b1;
        state_next.key      = mix_rot + pstb_pkg::POS_KEY_ADD;
      end else begin
        result.semantic_id    = control_word[pstb_pkg::SEM_W-1:0];
        result.is_flat        = control_word[pstb_pkg::FLAT_BIT];
        result.no_perspective = control_word[pstb_pkg::NOPERS_BIT];
        state_next.key        = mix_rot;
      end
      state_next.next_entry = entry_inc;
      result.table_done     = (entry_inc >= state.count);
    end else begin
      // word beyond the count, state left alone
      result.entry_index = state.next_entry;
      result.accepted    = 1'b0;
    end

    result.entry_count = state_next.count;
    result.table_key   = state_next.key;
  end

endmodule

FILE: hw/rtl/pstb_core.sv
// input register, table state and result register around the step logic
module pstb_core #(
  parameter int MAX_INPUTS = pstb_pkg::MAX_INPUTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pstb_pkg::WORD_W-1:0] ps_in_control,
  pstb_in_if.sink                     words,
  pstb_out_if.source                  entries
);

  logic                        in_valid;
  logic                        in_action;
  logic [pstb_pkg::WORD_W-1:0] in_word;
  logic                        out_valid;
  pstb_pkg::result_t           out_data;
  pstb_pkg::state_t            state;
  pstb_pkg::state_t            state_next;
  pstb_pkg::result_t           step_result;
  logic                        advance;

  assign advance     = !out_valid || entries.ready;
  assign words.ready = !in_valid || advance;

  pstb_step #(.MAX_INPUTS(MAX_INPUTS)) u_step (
    .action        (in_action),
    .control_word  (in_word),
    .ps_in_control (ps_in_control),
    .state         (state),
    .state_next    (state_next),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (words.ready) begin
        in_valid <= words.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
        if (in_valid) begin
          state <= state_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      in_action <= words.action;
      in_word   <= words.control_word;
    end
    if (advance && in_valid) begin
      out_data <= step_result;
    end
  end

  assign entries.valid          = out_valid;
  assign entries.entry_index    = out_data.entry_index;
  assign entries.semantic_id    = out_data.semantic_id;
  assign entries.is_position    = out_data.is_position;
  assign entries.is_flat        = out_data.is_flat;
  assign entries.no_perspective = out_data.no_perspective;
  assign entries.param_gen      = out_data.param_gen;
  assign entries.param_gen_gpr  = out_data.param_gen_gpr;
  assign entries.entry_count    = out_data.entry_count;
  assign entries.table_key      = out_data.table_key;
  assign entries.accepted       = out_data.accepted;
  assign entries.table_done     = out_data.table_done;

endmodule

FILE: hw/rtl/pixel_shader_input_table_builder.sv
// top level of the pixel shader input table builder
//
// words carries input transactions: action 0 begins a table from the
// ps_in_control register, action 1 supplies the next per-input control word.
// entries carries one result transaction per input transaction: the table
// entry, the clamped count, parameter generation fields and the running key.
// ps_in_control lies at byte address 0 of the apb port; write it only while
// no transaction is in flight.
// an input transaction is registered in the input register on acceptance and
// its result is registered in the result register. one transaction per cycle
// is sustained while entries.ready stays high; the key update is a 64-bit add,
// a fixed rotate and, for the position entry, a constant add.
// synchronous reset clears the key, the entry counter, the count, the
// register and both valid flags. when the receiver stalls the result
// register holds, one more transaction waits in the input register, and
// then words.ready drops until entries.ready returns.
module pixel_shader_input_table_builder #(
  parameter int MAX_INPUTS = pstb_pkg::MAX_INPUTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pstb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pstb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pstb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  pstb_in_if.sink                         words,
  pstb_out_if.source                      entries
);

  logic [pstb_pkg::WORD_W-1:0] ps_in_control;

  pstb_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .ps_in_control (ps_in_control)
  );

  pstb_core #(.MAX_INPUTS(MAX_INPUTS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .ps_in_control (ps_in_control),
    .words         (words),
    .entries       (entries)
  );

endmodule

FILE: sim/tb_pixel_shader_input_table_builder.sv
// testbench for the pixel shader input table builder: directed and random tables checked against a predictor
module tb_pixel_shader_input_table_builder;
  import pstb_pkg::*;

  localparam int N_MAX       = MAX_INPUTS_DEF;
  localparam int N_ITEMS     = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [APB_ADDR_W-1:0] CTL_ADDR = APB_ADDR_W'(4 * int'(REG_PS_IN_CONTROL));

  class entry_table_checker;
    logic [WORD_W-1:0] ctl_reg;
    logic [KEY_W-1:0]  key_acc;
    logic [CNT_W-1:0]  next_idx;
    logic [CNT_W-1:0]  table_len;
    result_t           pending_entries[$];
    int                errors;

    function new();
      ctl_reg   = '0;
      key_acc   = '0;
      next_idx  = '0;
      table_len = '0;
      errors    = 0;
    endfunction

    function logic [KEY_W-1:0] rot_r(logic [KEY_W-1:0] x, int n);
      return (x >> n) | (x << (KEY_W - n));
    endfunction

    function logic [KEY_W-1:0] rot_l(logic [KEY_W-1:0] x, int n);
      return (x << n) | (x >> (KEY_W - n));
    endfunction

    function string entry_text(result_t r);
      return $sformatf({"idx %0d sem %02h pos %0b flat %0b np %0b pgen %0h gpr %0d",
                        " cnt %0d key %016h acc %0b done %0b"},
                       r.entry_index, r.semantic_id, r.is_position, r.is_flat,
                       r.no_perspective, r.param_gen, r.param_gen_gpr, r.entry_count,
                       r.table_key, r.accepted, r.table_done);
    endfunction

    function void note_word(logic act, logic [WORD_W-1:0] w);
      result_t           r;
      logic              pos_en;
      logic [POS_W-1:0]  pos_addr;
      logic [PGEN_W-1:0] pgen;
      logic [GPR_W-1:0]  gpr;
      logic [KEY_W-1:0]  k;
      int                cnt;
      pos_en   = ctl_reg[8];
      pos_addr = ctl_reg[14:10];
      pgen     = ctl_reg[18:15];
      gpr      = ctl_reg[25:19];
      r = '0;
      r.accepted = 1'b1;
      if (act == ACT_BEGIN) begin
        cnt = int'(ctl_reg[5:0]);
        if (cnt > N_MAX) cnt = N_MAX;
        k = '0;
        if (pos_en) k += KEY_W'(pos_addr) + 64'd1;
        if (pgen != '0) begin
          k += rot_r(KEY_W'(pgen), PGEN_ROT);
          k += rot_r(KEY_W'(gpr), GPR_ROT);
        end
        key_acc   = k;
        next_idx  = '0;
        table_len = CNT_W'(cnt);
        r.table_done = (table_len == '0);
      end else if (next_idx < table_len) begin
        k = rot_l(key_acc + KEY_W'(w), KEY_ROT_LEFT);
        r.entry_index = next_idx;
        if (pos_en && next_idx == CNT_W'(pos_addr)) begin
          r.is_position = 1'b1;
          k += POS_KEY_ADD;
        end else begin
          r.semantic_id    = w[SEM_W-1:0];
          r.is_flat        = w[FLAT_BIT];
          r.no_perspective = w[NOPERS_BIT];
        end
        key_acc  = k;
        next_idx = next_idx + 1'b1;
        r.table_done = (next_idx >= table_len);
      end else begin
        r.entry_index = next_idx;
        r.accepted    = 1'b0;
        r.table_done  = 1'b1;
      end
      r.param_gen     = pgen;
      r.param_gen_gpr = (pgen != '0) ? gpr : '0;
      r.entry_count   = table_len;
      r.table_key     = key_acc;
      pending_entries.push_back(r);
    endfunction

    function void check_entry(result_t got);
      result_t want;
      if (pending_entries.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry: %s", entry_text(got));
        return;
      end
      want = pending_entries.pop_front();
      if (got.entry_index != want.entry_index || got.semantic_id != want.semantic_id ||
          got.is_position != want.is_position || got.is_flat != want.is_flat ||
          got.no_perspective != want.no_perspective || got.param_gen != want.param_gen ||
          got.param_gen_gpr != want.param_gen_gpr || got.entry_count != want.entry_count ||
          got.table_key != want.table_key || got.accepted != want.accepted ||
          got.table_done != want.table_done) begin
        errors++;
        if (errors <= 10) begin
          $display("entry mismatch: expected %s", entry_text(want));
          $display("                actual   %s", entry_text(got));
        end
      end
    endfunction

    function int outstanding();
      return pending_entries.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pstb_in_if  words_if ();
  pstb_out_if entries_if ();

  entry_table_checker sb = new();
  int stall_pct = 37;

  pixel_shader_input_table_builder #(.MAX_INPUTS(N_MAX)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .words   (words_if),
    .entries (entries_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    entries_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      entries_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_t seen;
    if (!rst) begin
      if (entries_if.valid && entries_if.ready) begin
        seen.entry_index    = entries_if.entry_index;
        seen.semantic_id    = entries_if.semantic_id;
        seen.is_position    = entries_if.is_position;
        seen.is_flat        = entries_if.is_flat;
        seen.no_perspective = entries_if.no_perspective;
        seen.param_gen      = entries_if.param_gen;
        seen.param_gen_gpr  = entries_if.param_gen_gpr;
        seen.entry_count    = entries_if.entry_count;
        seen.table_key      = entries_if.table_key;
        seen.accepted       = entries_if.accepted;
        seen.table_done     = entries_if.table_done;
        sb.check_entry(seen);
      end
      if (words_if.valid && words_if.ready)
        sb.note_word(words_if.action, words_if.control_word);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((words_if.valid && words_if.ready) || (entries_if.valid && entries_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send(input logic act, input logic [WORD_W-1:0] w);
    words_if.valid        <= 1'b1;
    words_if.action       <= act;
    words_if.control_word <= w;
    @(posedge clk);
    while (!words_if.ready) @(posedge clk);
    while ($urandom_range(99) < stall_pct) begin
      words_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    words_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_ctl(input logic [WORD_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CTL_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.ctl_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] make_ctl(int cnt, bit pos_en, int pos_addr,
                                                  int pgen, int gpr);
    logic [WORD_W-1:0] v;
    v = '0;
    v[5:0]   = CNT_W'(cnt);
    v[8]     = pos_en;
    v[14:10] = POS_W'(pos_addr);
    v[18:15] = PGEN_W'(pgen);
    v[25:19] = GPR_W'(gpr);
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] rand_ctl();
    logic [WORD_W-1:0] v;
    int                n;
    v = $urandom;
    case ($urandom_range(5))
      0: ;
      1: begin
        case ($urandom_range(2))
          0: v[5:0] = 6'd0;
          1: v[5:0] = 6'(N_MAX);
          default: v[5:0] = 6'h3f;
        endcase
      end
      default: v[5:0] = CNT_W'($urandom_range(1, 10));
    endcase
    n = (int'(v[5:0]) > N_MAX) ? N_MAX : int'(v[5:0]);
    if (n > 0 && $urandom_range(1)) v[14:10] = POS_W'($urandom_range(0, n - 1));
    if ($urandom_range(3) == 0) v[18:15] = '0;
    return v;
  endfunction

  initial begin : stimulus
    logic [WORD_W-1:0] ctl;
    int n, len, shape, real_items, phase;
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    words_if.valid        <= 1'b0;
    words_if.action       <= ACT_BEGIN;
    words_if.control_word <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // word before any table, then an empty table
    send(ACT_WORD, 32'hffff_ffff);
    send(ACT_BEGIN, 32'h0);
    send(ACT_WORD, 32'h0);
    drain();

    // short table with position in the middle and a word past the end
    write_ctl(make_ctl(3, 1'b1, 1, 15, 127));
    send(ACT_BEGIN, 32'hffff_ffff);
    send(ACT_WORD, 32'hffff_ffff);
    send(ACT_WORD, 32'h0000_1405);
    send(ACT_WORD, 32'h0);
    send(ACT_WORD, 32'hffff_ffff);
    drain();

    // every register bit set, restarted mid-table
    write_ctl(32'hffff_ffff);
    send(ACT_BEGIN, 32'h0);
    send(ACT_WORD, 32'h0000_0400);
    send(ACT_WORD, 32'h0000_1000);
    send(ACT_WORD, 32'hffff_ffff);
    send(ACT_BEGIN, 32'h0);
    drain();

    // count above the clamp, position at the first slot
    write_ctl(make_ctl(33, 1'b1, 0, 0, 0));
    send(ACT_BEGIN, 32'h0);
    send(ACT_WORD, 32'hffff_ffff);
    drain();

    // position beyond the count, gpr without a generation mode
    write_ctl(make_ctl(2, 1'b1, 5, 0, 127));
    send(ACT_BEGIN, 32'h0);
    send(ACT_WORD, 32'h0000_14ff);
    send(ACT_WORD, 32'h8000_0000);
    send(ACT_WORD, 32'h0);
    drain();
    write_ctl(32'h0);

    real_items = 0;
    phase = 0;
    while (real_items < N_ITEMS) begin
      drain();
      stall_pct = (phase >= 12 && phase < 22) ? 0 : 37;
      ctl = rand_ctl();
      write_ctl(ctl);
      n = (int'(ctl[5:0]) > N_MAX) ? N_MAX : int'(ctl[5:0]);
      repeat ($urandom_range(1, 3)) begin
        send(ACT_BEGIN, $urandom);
        real_items++;
        shape = $urandom_range(9);
        len = n;
        if (shape == 0 && n > 0) len = $urandom_range(0, n - 1);
        for (int i = 0; i < len; i++) begin
          send(ACT_WORD, $urandom);
          real_items++;
        end
        if (shape == 1) repeat ($urandom_range(1, 3)) send(ACT_WORD, $urandom);
        if (shape == 2) repeat ($urandom_range(1, 4)) send(1'($urandom_range(1)), $urandom);
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: pixel_shader_input_table_builder.f
hw/rtl/pstb_pkg.sv
hw/rtl/pstb_if.sv
hw/rtl/pstb_apb_regs.sv
hw/rtl/pstb_step.sv
hw/rtl/pstb_core.sv
hw/rtl/pixel_shader_input_table_builder.sv
sim/tb_pixel_shader_input_table_builder.sv
